>>> sv/ddo_pkg.sv
// ddo_pkg: shared types, constants and the CORDIC arctangent table for the
// odometry tracker. No dependencies; used by ddo_serial_unit and the top level.
`default_nettype none

package ddo_pkg;

  // fixed-point constants (Q8.24 and Q16.16 radians, CORDIC gain in Q2.30)
  localparam logic [26:0]        TWO_PI_Q24  = 27'd105414357;
  localparam logic [18:0]        TWO_PI_Q16  = 19'd411775;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam int                 CORDIC_N    = 24;

  // marker correction divides the error by ten, rounded
  localparam int MARKER_DIV = 10;

  // serial unit sizing
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 49;
  localparam int NUM_W     = 49;
  localparam int DVS_W     = 29;

  // register map, by word index
  localparam logic [2:0] REG_WHEEL_RADIUS  = 3'd0;
  localparam logic [2:0] REG_WHEEL_SPACING = 3'd1;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd2;
  localparam logic [2:0] REG_POLE_COUNT    = 3'd3;
  localparam logic [2:0] REG_GEAR          = 3'd4;

  localparam logic [15:0] RADIUS_RST  = 16'd1835;
  localparam logic [15:0] SPACING_RST = 16'd8651;
  localparam logic [15:0] PERIOD_RST  = 16'd2621;
  localparam logic [7:0]  POLES_RST   = 8'd8;
  localparam logic [9:0]  GEAR_RST    = 10'd120;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic               start;
    logic               is_div;
    logic [31:0]        mcand;
    logic [31:0]        mplier;
    logic [NUM_W-1:0]   num;
    logic [DVS_W-1:0]   dvs;
  } ddo_req_t;

  typedef enum logic [19:0] {
    S_IDLE = 20'b0000_0000_0000_0000_0001,
    S_W1M  = 20'b0000_0000_0000_0000_0010,
    S_W1D  = 20'b0000_0000_0000_0000_0100,
    S_W2M  = 20'b0000_0000_0000_0000_1000,
    S_W2D  = 20'b0000_0000_0000_0001_0000,
    S_V1M  = 20'b0000_0000_0000_0010_0000,
    S_V2M  = 20'b0000_0000_0000_0100_0000,
    S_WED  = 20'b0000_0000_0000_1000_0000,
    S_DSM  = 20'b0000_0000_0001_0000_0000,
    S_DTHM = 20'b0000_0000_0010_0000_0000,
    S_ANGD = 20'b0000_0000_0100_0000_0000,
    S_COR  = 20'b0000_0000_1000_0000_0000,
    S_PXM  = 20'b0000_0001_0000_0000_0000,
    S_PYM  = 20'b0000_0010_0000_0000_0000,
    S_HDD  = 20'b0000_0100_0000_0000_0000,
    S_MXD  = 20'b0000_1000_0000_0000_0000,
    S_MYD  = 20'b0001_0000_0000_0000_0000,
    S_MDD  = 20'b0010_0000_0000_0000_0000,
    S_MHD  = 20'b0100_0000_0000_0000_0000,
    S_OUT  = 20'b1000_0000_0000_0000_0000
  } ddo_state_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] cordic_atan(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/ddo_serial_unit.sv
// ddo_serial_unit: shared bit-serial unsigned multiplier (32 steps) and
// restoring divider (49 steps, quotient low 32 bits and remainder). Uses ddo_pkg.
`default_nettype none

module ddo_serial_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ddo_pkg::ddo_req_t         req,
  output logic                      done,
  output logic [63:0]               prod,
  output logic [31:0]               quo,
  output logic [ddo_pkg::DVS_W-1:0] rem
);

  logic                        busy_r;
  logic                        done_r;
  logic                        div_r;
  logic [5:0]                  cnt_r;
  logic [31:0]                 hi_r;
  logic [31:0]                 lo_r;
  logic [31:0]                 mc_r;
  logic [ddo_pkg::NUM_W-1:0]   dnd_r;
  logic [ddo_pkg::DVS_W-1:0]   dvs_r;
  logic [ddo_pkg::DVS_W-1:0]   rem_r;
  logic [31:0]                 quo_r;

  logic [32:0]                 msum;
  logic [ddo_pkg::DVS_W:0]     trial;
  logic [ddo_pkg::DVS_W:0]     tdiff;
  logic                        qbit;

  always_comb begin
    msum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : 33'd0);
    trial = {rem_r, dnd_r[ddo_pkg::NUM_W-1]};
    tdiff = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      if (req.is_div) begin
        dnd_r <= req.num;
        dvs_r <= req.dvs;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 6'(ddo_pkg::DIV_STEPS - 1);
      end else begin
        hi_r  <= '0;
        lo_r  <= req.mplier;
        mc_r  <= req.mcand;
        cnt_r <= 6'(ddo_pkg::MUL_STEPS - 1);
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (div_r) begin
        rem_r <= qbit ? tdiff[ddo_pkg::DVS_W-1:0] : trial[ddo_pkg::DVS_W-1:0];
        dnd_r <= {dnd_r[ddo_pkg::NUM_W-2:0], 1'b0};
        quo_r <= {quo_r[30:0], qbit};
      end else begin
        hi_r <= msum[32:1];
        lo_r <= {msum[0], lo_r[31:1]};
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> sv/diff_drive_odometry.sv
// diff_drive_odometry: dead-reckoning pose tracker, sequencer, CORDIC and state.
// Depends on ddo_pkg and ddo_serial_unit.
//
//  port group  | direction | handshake          | word
//  in_*        | input     | in_valid/in_stall  | mode, wheel counts, marker pose
//  out_*       | output    | out_valid/out_stall| pose, wheel rates, speed, sums
//  APB         | input     | psel/penable       | five setup registers
//
// An encoder word runs eight multiplies and five divides on the single serial
// multiply/divide unit and 24 CORDIC steps, one after the other; a marker word
// runs four divides. The result then goes into the output register.
// Synchronous active-low reset clears pose, sums and registers to defaults.
// in_stall is high from accept until the result is in the output register;
// a stalled result holds while the next word is worked on.
`default_nettype none

module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic signed [31:0] in_marker_x,
  input  logic signed [31:0] in_marker_y,
  input  logic signed [18:0] in_marker_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [18:0] out_pose_heading,
  output logic signed [31:0] out_wheel1_rate,
  output logic signed [31:0] out_wheel2_rate,
  output logic signed [31:0] out_body_speed,
  output logic signed [31:0] out_turn_rate,
  output logic signed [31:0] out_travelled,
  output logic signed [31:0] out_turned,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  function automatic logic [15:0] f_abs16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [31:0] f_abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] f_abs33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [31:0] f_sgn32(input logic neg, input logic [31:0] q);
    return neg ? (~q + 32'd1) : q;
  endfunction

  // fold a remainder of |a| mod 2pi back into [-pi, pi]
  function automatic logic [18:0] f_norm(input logic neg, input logic [18:0] rm);
    logic [19:0] r;
    r = (neg && rm != 19'd0) ? ({1'b0, ddo_pkg::TWO_PI_Q16} - {1'b0, rm}) : {1'b0, rm};
    if ($signed(r) > ddo_pkg::PI_Q16) r = r - {1'b0, ddo_pkg::TWO_PI_Q16};
    return r[18:0];
  endfunction

  function automatic logic [31:0] f_round16(input logic [63:0] p);
    logic [48:0] s;
    s = p[48:0] + 49'h8000;
    return s[47:16];
  endfunction

  function automatic logic [31:0] f_round30(input logic [63:0] p);
    logic [62:0] s;
    s = p[62:0] + 63'h2000_0000;
    return s[61:30];
  endfunction

  ddo_pkg::ddo_state_t state_r;
  logic                issued_r;
  logic                out_valid_r;

  logic [15:0] radius_r, spacing_r, period_r;
  logic [7:0]  poles_r;
  logic [9:0]  gear_r;

  logic [31:0] pos_x_r, pos_y_r, dist_r, angs_r;
  logic [18:0] heading_r;

  logic [15:0] c1_r, c2_r;
  logic [31:0] mx_r, my_r;
  logic [18:0] mh_r;
  logic [27:0] den_r;
  logic [31:0] w1_r, w2_r, v1_r, v2_r, ve_r, we_r, ds_r, dth_r;
  logic [18:0] delta_r;
  logic        sgn_r, sgn_nxt;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic signed [33:0] x_r, y_r, z_r;

  logic [31:0] o_px_r, o_py_r, o_w1_r, o_w2_r, o_ve_r, o_we_r, o_dist_r, o_angs_r;
  logic [18:0] o_hd_r;

  ddo_pkg::ddo_req_t         req;
  logic                      u_done;
  logic [63:0]               u_prod;
  logic [31:0]               u_quo;
  logic [ddo_pkg::DVS_W-1:0] u_rem;

  logic        accept, out_load, cfg_wr, run_st, cor_last;
  logic [7:0]  poles_e;
  logic [9:0]  gear_e;
  logic [15:0] spacing_e;
  logic [17:0] pg;
  logic [32:0] sum_v, diff_v, ang_a, hd_a, mx_d, my_d, mh_d;
  logic [33:0] ve_s;
  logic [32:0] hq_s;
  logic [31:0] ve_calc, h2;
  logic [18:0] nrm;
  logic signed [19:0] ang_n, ang_f, q20, t20, hd_new;
  logic        fold_neg;
  logic signed [33:0] dx, dy, at_c, x_abs_s, y_abs_s;
  logic signed [19:0] hd20;

  ddo_serial_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .done (u_done),
    .prod (u_prod),
    .quo  (u_quo),
    .rem  (u_rem)
  );

  assign in_stall = (state_r != ddo_pkg::S_IDLE);
  assign accept   = in_valid && (state_r == ddo_pkg::S_IDLE);
  assign out_load = (state_r == ddo_pkg::S_OUT) && (!out_valid_r || !out_stall);
  assign cfg_wr   = psel && penable && pwrite;
  assign run_st   = !(state_r == ddo_pkg::S_IDLE || state_r == ddo_pkg::S_COR ||
                      state_r == ddo_pkg::S_OUT);
  assign cor_last = (cnt_r == 5'(ddo_pkg::CORDIC_N - 1));
  assign pready   = 1'b1;

  always_comb begin
    poles_e   = (poles_r == 8'd0) ? 8'd1 : poles_r;
    gear_e    = (gear_r == 10'd0) ? 10'd1 : gear_r;
    spacing_e = (spacing_r == 16'd0) ? 16'd1 : spacing_r;
    pg        = {10'b0, poles_e} * {8'b0, gear_e};

    sum_v   = {v1_r[31], v1_r} + {v2_r[31], v2_r};
    diff_v  = {v1_r[31], v1_r} - {v2_r[31], v2_r};
    ve_s    = {1'b0, f_abs33(sum_v)} + 34'd1;
    ve_calc = f_sgn32(sum_v[32], ve_s[32:1]);
    hq_s    = {1'b0, f_abs32(dth_r)} + 33'd1;
    h2      = f_sgn32(dth_r[31], hq_s[32:1]);
    ang_a   = {{14{heading_r[18]}}, heading_r} + {h2[31], h2};
    hd_a    = {{14{heading_r[18]}}, heading_r} + {dth_r[31], dth_r};
    mx_d    = {mx_r[31], mx_r} - {pos_x_r[31], pos_x_r};
    my_d    = {my_r[31], my_r} - {pos_y_r[31], pos_y_r};
    mh_d    = {{14{mh_r[18]}}, mh_r} - {{14{heading_r[18]}}, heading_r};

    nrm   = f_norm(sgn_r, u_rem[18:0]);
    ang_n = signed'({nrm[18], nrm});
    fold_neg = 1'b0;
    ang_f    = ang_n;
    if (ang_n > ddo_pkg::HALF_PI_Q16) begin
      ang_f    = ang_n - ddo_pkg::PI_Q16;
      fold_neg = 1'b1;
    end else if (ang_n < -ddo_pkg::HALF_PI_Q16) begin
      ang_f    = ang_n + ddo_pkg::PI_Q16;
      fold_neg = 1'b1;
    end

    // marker heading pull, then one wrap step
    q20    = signed'(u_quo[19:0]);
    t20    = signed'({heading_r[18], heading_r}) + (sgn_r ? -q20 : q20);
    hd_new = t20;
    if (t20 > ddo_pkg::PI_Q16) begin
      hd_new = t20 - signed'({1'b0, ddo_pkg::TWO_PI_Q16});
    end else if (t20 < -ddo_pkg::PI_Q16) begin
      hd_new = t20 + signed'({1'b0, ddo_pkg::TWO_PI_Q16});
    end

    dx      = y_r >>> cnt_r;
    dy      = x_r >>> cnt_r;
    at_c    = ddo_pkg::cordic_atan(cnt_r);
    x_abs_s = x_r[33] ? -x_r : x_r;
    y_abs_s = y_r[33] ? -y_r : y_r;
    hd20    = signed'({heading_r[18], heading_r});
  end

  // launch requests to the serial unit
  always_comb begin
    req       = '0;
    req.start = run_st && !issued_r;
    sgn_nxt   = sgn_r;
    unique case (state_r)
      ddo_pkg::S_W1M, ddo_pkg::S_W2M: begin
        req.mcand  = {5'b0, ddo_pkg::TWO_PI_Q24};
        req.mplier = {16'b0, f_abs16((state_r == ddo_pkg::S_W1M) ? c1_r : c2_r)};
      end
      ddo_pkg::S_W1D, ddo_pkg::S_W2D: begin
        req.is_div = 1'b1;
        req.num    = u_prod[48:0] + {22'b0, den_r[27:1]};
        req.dvs    = {1'b0, den_r};
      end
      ddo_pkg::S_V1M: begin
        req.mcand  = f_abs32(w1_r);
        req.mplier = {16'b0, radius_r};
      end
      ddo_pkg::S_V2M: begin
        req.mcand  = f_abs32(w2_r);
        req.mplier = {16'b0, radius_r};
      end
      ddo_pkg::S_WED: begin
        req.is_div = 1'b1;
        req.num    = {f_abs33(diff_v), 16'b0} + {34'b0, spacing_e[15:1]};
        req.dvs    = {13'b0, spacing_e};
        sgn_nxt    = diff_v[32];
      end
      ddo_pkg::S_DSM: begin
        req.mcand  = f_abs32(ve_r);
        req.mplier = {16'b0, period_r};
      end
      ddo_pkg::S_DTHM: begin
        req.mcand  = f_abs32(we_r);
        req.mplier = {16'b0, period_r};
      end
      ddo_pkg::S_ANGD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33(ang_a)};
        req.dvs    = {10'b0, ddo_pkg::TWO_PI_Q16};
        sgn_nxt    = ang_a[32];
      end
      ddo_pkg::S_PXM: begin
        req.mcand  = f_abs32(ds_r);
        req.mplier = x_abs_s[31:0];
        sgn_nxt    = ds_r[31] ^ x_r[33] ^ neg_r;
      end
      ddo_pkg::S_PYM: begin
        req.mcand  = f_abs32(ds_r);
        req.mplier = y_abs_s[31:0];
        sgn_nxt    = ds_r[31] ^ y_r[33] ^ neg_r;
      end
      ddo_pkg::S_HDD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33(hd_a)};
        req.dvs    = {10'b0, ddo_pkg::TWO_PI_Q16};
        sgn_nxt    = hd_a[32];
      end
      ddo_pkg::S_MXD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33(mx_d)} + 49'(ddo_pkg::MARKER_DIV / 2);
        req.dvs    = 29'(ddo_pkg::MARKER_DIV);
        sgn_nxt    = mx_d[32];
      end
      ddo_pkg::S_MYD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33(my_d)} + 49'(ddo_pkg::MARKER_DIV / 2);
        req.dvs    = 29'(ddo_pkg::MARKER_DIV);
        sgn_nxt    = my_d[32];
      end
      ddo_pkg::S_MDD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33(mh_d)};
        req.dvs    = {10'b0, ddo_pkg::TWO_PI_Q16};
        sgn_nxt    = mh_d[32];
      end
      ddo_pkg::S_MHD: begin
        req.is_div = 1'b1;
        req.num    = {16'b0, f_abs33({{14{delta_r[18]}}, delta_r})} +
                     49'(ddo_pkg::MARKER_DIV / 2);
        req.dvs    = 29'(ddo_pkg::MARKER_DIV);
        sgn_nxt    = delta_r[18];
      end
      default: ;
    endcase
  end

  // control, architectural state and setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddo_pkg::S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      dist_r      <= '0;
      angs_r      <= '0;
      radius_r    <= ddo_pkg::RADIUS_RST;
      spacing_r   <= ddo_pkg::SPACING_RST;
      period_r    <= ddo_pkg::PERIOD_RST;
      poles_r     <= ddo_pkg::POLES_RST;
      gear_r      <= ddo_pkg::GEAR_RST;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ddo_pkg::REG_WHEEL_RADIUS:  radius_r  <= pwdata[15:0];
          ddo_pkg::REG_WHEEL_SPACING: spacing_r <= pwdata[15:0];
          ddo_pkg::REG_SAMPLE_PERIOD: period_r  <= pwdata[15:0];
          ddo_pkg::REG_POLE_COUNT:    poles_r   <= pwdata[7:0];
          ddo_pkg::REG_GEAR:          gear_r    <= pwdata[9:0];
          default: ;
        endcase
      end

      if (req.start) begin
        issued_r <= 1'b1;
      end else if (u_done) begin
        issued_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ddo_pkg::S_IDLE: begin
          if (accept) state_r <= in_mode ? ddo_pkg::S_MXD : ddo_pkg::S_W1M;
        end
        ddo_pkg::S_W1M:  if (u_done) state_r <= ddo_pkg::S_W1D;
        ddo_pkg::S_W1D:  if (u_done) state_r <= ddo_pkg::S_W2M;
        ddo_pkg::S_W2M:  if (u_done) state_r <= ddo_pkg::S_W2D;
        ddo_pkg::S_W2D:  if (u_done) state_r <= ddo_pkg::S_V1M;
        ddo_pkg::S_V1M:  if (u_done) state_r <= ddo_pkg::S_V2M;
        ddo_pkg::S_V2M:  if (u_done) state_r <= ddo_pkg::S_WED;
        ddo_pkg::S_WED:  if (u_done) state_r <= ddo_pkg::S_DSM;
        ddo_pkg::S_DSM:  if (u_done) state_r <= ddo_pkg::S_DTHM;
        ddo_pkg::S_DTHM: if (u_done) state_r <= ddo_pkg::S_ANGD;
        ddo_pkg::S_ANGD: if (u_done) state_r <= ddo_pkg::S_COR;
        ddo_pkg::S_COR:  if (cor_last) state_r <= ddo_pkg::S_PXM;
        ddo_pkg::S_PXM: begin
          if (u_done) begin
            pos_x_r <= pos_x_r + f_sgn32(sgn_r, f_round30(u_prod));
            state_r <= ddo_pkg::S_PYM;
          end
        end
        ddo_pkg::S_PYM: begin
          if (u_done) begin
            pos_y_r <= pos_y_r + f_sgn32(sgn_r, f_round30(u_prod));
            state_r <= ddo_pkg::S_HDD;
          end
        end
        ddo_pkg::S_HDD: begin
          if (u_done) begin
            heading_r <= nrm;
            dist_r    <= dist_r + ds_r;
            angs_r    <= angs_r + dth_r;
            state_r   <= ddo_pkg::S_OUT;
          end
        end
        ddo_pkg::S_MXD: begin
          if (u_done) begin
            pos_x_r <= pos_x_r + f_sgn32(sgn_r, u_quo);
            state_r <= ddo_pkg::S_MYD;
          end
        end
        ddo_pkg::S_MYD: begin
          if (u_done) begin
            pos_y_r <= pos_y_r + f_sgn32(sgn_r, u_quo);
            state_r <= ddo_pkg::S_MDD;
          end
        end
        ddo_pkg::S_MDD:  if (u_done) state_r <= ddo_pkg::S_MHD;
        ddo_pkg::S_MHD: begin
          if (u_done) begin
            heading_r <= hd_new[18:0];
            state_r   <= ddo_pkg::S_OUT;
          end
        end
        ddo_pkg::S_OUT:  if (out_load) state_r <= ddo_pkg::S_IDLE;
        default:         state_r <= ddo_pkg::S_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) sgn_r <= sgn_nxt;

    if (accept) begin
      c1_r  <= in_left_count;
      c2_r  <= in_right_count;
      mx_r  <= in_marker_x;
      my_r  <= in_marker_y;
      mh_r  <= in_marker_heading;
      den_r <= {pg, 10'b0};
      w1_r  <= '0;
      w2_r  <= '0;
      ve_r  <= '0;
      we_r  <= '0;
    end

    if (state_r == ddo_pkg::S_WED && req.start) ve_r <= ve_calc;

    if (u_done) begin
      unique case (state_r)
        ddo_pkg::S_W1D:  w1_r  <= f_sgn32(c1_r[15], u_quo);
        ddo_pkg::S_W2D:  w2_r  <= f_sgn32(c2_r[15], u_quo);
        ddo_pkg::S_V1M:  v1_r  <= f_sgn32(w1_r[31], f_round16(u_prod));
        ddo_pkg::S_V2M:  v2_r  <= f_sgn32(w2_r[31], f_round16(u_prod));
        ddo_pkg::S_WED:  we_r  <= f_sgn32(sgn_r, u_quo);
        ddo_pkg::S_DSM:  ds_r  <= f_sgn32(ve_r[31], f_round16(u_prod));
        ddo_pkg::S_DTHM: dth_r <= f_sgn32(we_r[31], f_round16(u_prod));
        ddo_pkg::S_ANGD: begin
          x_r   <= ddo_pkg::CORDIC_K;
          y_r   <= '0;
          z_r   <= signed'({ang_f, 14'b0});
          neg_r <= fold_neg;
          cnt_r <= '0;
        end
        ddo_pkg::S_MDD:  delta_r <= nrm;
        default: ;
      endcase
    end

    if (state_r == ddo_pkg::S_COR) begin
      cnt_r <= cnt_r + 5'd1;
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at_c;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at_c;
      end
    end

    if (out_load) begin
      o_px_r   <= pos_x_r;
      o_py_r   <= pos_y_r;
      o_hd_r   <= heading_r;
      o_w1_r   <= w1_r;
      o_w2_r   <= w2_r;
      o_ve_r   <= ve_r;
      o_we_r   <= we_r;
      o_dist_r <= dist_r;
      o_angs_r <= angs_r;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ddo_pkg::REG_WHEEL_RADIUS:  prdata = {16'b0, radius_r};
      ddo_pkg::REG_WHEEL_SPACING: prdata = {16'b0, spacing_r};
      ddo_pkg::REG_SAMPLE_PERIOD: prdata = {16'b0, period_r};
      ddo_pkg::REG_POLE_COUNT:    prdata = {24'b0, poles_r};
      ddo_pkg::REG_GEAR:          prdata = {22'b0, gear_r};
      default:                    prdata = '0;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = signed'(o_px_r);
  assign out_pose_y       = signed'(o_py_r);
  assign out_pose_heading = signed'(o_hd_r);
  assign out_wheel1_rate  = signed'(o_w1_r);
  assign out_wheel2_rate  = signed'(o_w2_r);
  assign out_body_speed   = signed'(o_ve_r);
  assign out_turn_rate    = signed'(o_we_r);
  assign out_travelled    = signed'(o_dist_r);
  assign out_turned       = signed'(o_angs_r);

  // heading stays wrapped
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hd20 <= ddo_pkg::PI_Q16) && (hd20 >= -ddo_pkg::PI_Q16))
    else $error("heading out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ddo_pkg::S_IDLE))
    else $error("accepted word did not start work");

  a_done_only_issued: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (issued_r && state_r != ddo_pkg::S_IDLE))
    else $error("serial unit finished with nothing issued");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ddo_pkg::S_OUT))
    else $error("result word loaded outside output state");

endmodule

`default_nettype wire
